// ===== rtl/contiguous_fit_allocator_defines.svh =====
// Assertion helpers used by the allocator RTL.
`ifndef CONTIGUOUS_FIT_ALLOCATOR_DEFINES_SVH
`define CONTIGUOUS_FIT_ALLOCATOR_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CFA_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("allocator check failed");

// The consequent must hold in the cycle after the antecedent.
`define CFA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("allocator check failed");

`endif

// ===== rtl/cfa_pkg.sv =====
package cfa_pkg;

  // Request word.
  typedef struct packed {
    logic        kind;
    logic [16:0] request_size;
    logic [1:0]  strategy;
    logic [15:0] handle;
  } in_word_t;

  // Result word.
  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] new_handle;
    logic [15:0] base_address;
    logic [16:0] free_total;
    logic [16:0] allocated_total;
    logic [16:0] largest_free;
  } out_word_t;

  // One free range held in a cell of the free ring.
  typedef struct packed {
    logic        valid;
    logic [15:0] start;
    logic [16:0] len;
  } free_ent_t;

  // One live allocation held in a cell of the table ring.
  typedef struct packed {
    logic        valid;
    logic [15:0] handle;
    logic [15:0] addr;
    logic [16:0] len;
  } live_ent_t;

  // What a cell loads at the next edge.
  typedef enum logic [2:0] {
    CellHold,
    CellRight,
    CellLeft,
    CellLoad,
    CellClear
  } cell_op_e;

  // Address width of the managed range; capacity is limited to 2^AddrBits.
  localparam int AddrBits = 16;
  localparam logic [16:0] CapMax = 17'(1 << AddrBits);

  localparam logic KindAlloc = 1'b0;
  localparam logic KindFree  = 1'b1;

  localparam logic [1:0] StratBest  = 2'd1;
  localparam logic [1:0] StratWorst = 2'd2;

  localparam logic [2:0] StatOk       = 3'd0;
  localparam logic [2:0] StatZeroSize = 3'd1;
  localparam logic [2:0] StatNoFit    = 3'd2;
  localparam logic [2:0] StatUnknown  = 3'd3;
  localparam logic [2:0] StatFull     = 3'd4;

  localparam logic [15:0] HandleMax = 16'hFFFF;

endpackage

// ===== rtl/cfa_cell.sv =====
// One cell of a ring: a register that holds, loads, clears or takes a neighbor's word.
module cfa_cell #(
  parameter int W = 34,
  parameter logic [W-1:0] RstVal = '0
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cfa_pkg::cell_op_e op_i,
  input  logic [W-1:0]      left_i,
  input  logic [W-1:0]      right_i,
  input  logic [W-1:0]      load_i,
  output logic [W-1:0]      q_o
);

  logic [W-1:0] val_d, val_q;

  // Select the next content of the cell.
  always_comb begin
    case (op_i)
      cfa_pkg::CellHold:  val_d = val_q;
      cfa_pkg::CellRight: val_d = right_i;
      cfa_pkg::CellLeft:  val_d = left_i;
      cfa_pkg::CellLoad:  val_d = load_i;
      cfa_pkg::CellClear: val_d = '0;
      default:            val_d = val_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      val_q <= RstVal;
    end else begin
      val_q <= val_d;
    end
  end

  assign q_o = val_q;

endmodule

// ===== rtl/contiguous_fit_allocator.sv =====
// Contiguous range allocator with first, best and worst fit placement.
// Requests arrive on in_valid_i / in_stall_o as one in_word_i word; results
// leave on out_valid_o / out_stall_i as one out_word_o word, one per request.
// A word moves at an edge where valid is high and stall is low.
// The free list is a ring of N = MAX_ALLOCS+1 cells and the table a ring of
// MAX_ALLOCS cells; a pass rotates a ring by one cell a cycle and the
// controller looks only at the head cell. An allocate scans the free ring,
// then the table (once more per skipped handle), commits and totals the free
// ring; a free scans the table, then the free ring, commits and totals; a
// failed request goes from its scans straight to the totals. One request is
// in work at a time and the input is taken again in the cycle after the
// result is registered, so no new request is taken before the last has its result.
// The next request is taken while a result still waits in the output
// register, which holds while stalled; a second result then waits in work.
// Reset leaves one free range [0, capacity) with capacity 65536 (limited to
// 2^AddrBits), an empty table and handle counter 1. A write on cfg_we_i sets
// capacity and reinitializes everything at that edge; the user must make it
// only while the block is idle, as the block itself does not enforce this.
`include "contiguous_fit_allocator_defines.svh"
module contiguous_fit_allocator #(
  parameter int MAX_ALLOCS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  cfa_pkg::in_word_t  in_word_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output cfa_pkg::out_word_t out_word_o,
  input  logic               cfg_we_i,
  input  logic [16:0]        cfg_wdata_i
);

  localparam int N     = MAX_ALLOCS + 1;
  localparam int FIdxW = $clog2(N);
  localparam int FCntW = $clog2(N + 1);
  localparam int LIdxW = $clog2(MAX_ALLOCS);
  localparam logic [16:0] CapMax = cfa_pkg::CapMax;
  localparam cfa_pkg::free_ent_t FreeRst = '{valid: 1'b1, start: 16'h0, len: CapMax};
  localparam int FreeW = $bits(cfa_pkg::free_ent_t);
  localparam int LiveW = $bits(cfa_pkg::live_ent_t);

  typedef enum logic [2:0] {
    StIdle, StFscan, StLscan, StDecide, StCommit, StTscan, StOut
  } state_e;

  function automatic logic [15:0] next_handle(input logic [15:0] h);
    next_handle = (h == cfa_pkg::HandleMax) ? 16'd1 : h + 16'd1;
  endfunction

  state_e state_q;
  cfa_pkg::in_word_t  req_q;
  cfa_pkg::out_word_t out_word_q;
  logic out_valid_q;

  logic [FIdxW-1:0] cnt_q;
  logic [FCntW-1:0] fc_q;
  logic [16:0] cap_q, atot_q, ftot_q, big_q;
  logic [15:0] hc_q, h_q, newh_q, base_q;
  logic [2:0]  status_q;

  // Free-ring scan trackers.
  logic             sel_found_q;
  logic [FCntW-1:0] sel_idx_q;
  logic [15:0]      sel_start_q;
  logic [16:0]      sel_len_q;
  logic [FCntW-1:0] p_q;
  logic [15:0]      prev_start_q, r_start_q;
  logic [16:0]      prev_len_q, r_len_q;
  logic             r_found_q;

  // Table scan trackers.
  logic             slot_found_q, hit_found_q;
  logic [LIdxW-1:0] slot_idx_q, hit_idx_q;
  logic [15:0]      hit_addr_q;
  logic [16:0]      hit_len_q;

  cfa_pkg::free_ent_t f_q [N];
  cfa_pkg::live_ent_t l_q [MAX_ALLOCS];
  cfa_pkg::cell_op_e  f_op [N];
  cfa_pkg::cell_op_e  l_op [MAX_ALLOCS];
  cfa_pkg::free_ent_t f_ld, f_tail, fc_ld_ent;
  cfa_pkg::live_ent_t l_ld;

  logic             fc_ld, fc_shl, fc_shr;
  logic [FCntW-1:0] fc_ld_idx, fc_p, fc_next;
  logic             left_m, right_m, is_alloc;
  logic [16:0]      cap_new;
  logic [15:0]      key;
  logic             rot_f;
  logic             last_f, last_l;

  assign is_alloc = (req_q.kind == cfa_pkg::KindAlloc);
  assign key      = is_alloc ? h_q : req_q.handle;
  assign rot_f    = (state_q == StFscan) || (state_q == StTscan);
  assign last_f   = (cnt_q == FIdxW'(N - 1));
  assign last_l   = (cnt_q == FIdxW'(MAX_ALLOCS - 1));

  // Clamp a written capacity into its legal range.
  always_comb begin
    cap_new = cfg_wdata_i;
    if (cfg_wdata_i == 17'd0) begin
      cap_new = 17'd1;
    end else if (cfg_wdata_i > CapMax) begin
      cap_new = CapMax;
    end
  end

  // Free-list edit that the commit cycle applies to the ring.
  always_comb begin
    fc_ld     = 1'b0;
    fc_shl    = 1'b0;
    fc_shr    = 1'b0;
    fc_ld_idx = '0;
    fc_p      = '0;
    fc_ld_ent = '0;
    fc_next   = fc_q;
    left_m    = (p_q != '0) &&
                ((17'(prev_start_q) + prev_len_q) == 17'(hit_addr_q));
    right_m   = r_found_q && ((17'(hit_addr_q) + hit_len_q) == 17'(r_start_q));
    if (is_alloc) begin
      fc_p = sel_idx_q;
      if (sel_len_q == req_q.request_size) begin
        fc_shl  = 1'b1;
        fc_next = fc_q - FCntW'(1);
      end else begin
        fc_ld     = 1'b1;
        fc_ld_idx = sel_idx_q;
        fc_ld_ent = '{valid: 1'b1, start: sel_start_q + req_q.request_size[15:0],
                      len: sel_len_q - req_q.request_size};
      end
    end else if (left_m && right_m) begin
      fc_ld     = 1'b1;
      fc_ld_idx = p_q - FCntW'(1);
      fc_ld_ent = '{valid: 1'b1, start: prev_start_q,
                    len: prev_len_q + hit_len_q + r_len_q};
      fc_shl    = 1'b1;
      fc_p      = p_q;
      fc_next   = fc_q - FCntW'(1);
    end else if (left_m) begin
      fc_ld     = 1'b1;
      fc_ld_idx = p_q - FCntW'(1);
      fc_ld_ent = '{valid: 1'b1, start: prev_start_q, len: prev_len_q + hit_len_q};
    end else if (right_m) begin
      fc_ld     = 1'b1;
      fc_ld_idx = p_q;
      fc_ld_ent = '{valid: 1'b1, start: hit_addr_q, len: r_len_q + hit_len_q};
    end else if (fc_q != FCntW'(N)) begin
      fc_ld     = 1'b1;
      fc_ld_idx = p_q;
      fc_shr    = 1'b1;
      fc_p      = p_q;
      fc_ld_ent = '{valid: 1'b1, start: hit_addr_q, len: hit_len_q};
      fc_next   = fc_q + FCntW'(1);
    end
  end

  assign f_ld   = cfg_we_i ? cfa_pkg::free_ent_t'{valid: 1'b1, start: 16'h0, len: cap_new}
                           : fc_ld_ent;
  assign f_tail = rot_f ? f_q[0] : '0;
  assign l_ld   = '{valid: 1'b1, handle: h_q, addr: sel_start_q, len: req_q.request_size};

  // Free ring cells.
  for (genvar i = 0; i < N; i++) begin : g_free
    always_comb begin
      f_op[i] = cfa_pkg::CellHold;
      if (cfg_we_i) begin
        f_op[i] = (i == 0) ? cfa_pkg::CellLoad : cfa_pkg::CellClear;
      end else if (rot_f) begin
        f_op[i] = cfa_pkg::CellRight;
      end else if (state_q == StCommit) begin
        if (fc_ld && (FCntW'(i) == fc_ld_idx)) begin
          f_op[i] = cfa_pkg::CellLoad;
        end else if (fc_shl && (FCntW'(i) >= fc_p)) begin
          f_op[i] = cfa_pkg::CellRight;
        end else if (fc_shr && (FCntW'(i) > fc_p)) begin
          f_op[i] = cfa_pkg::CellLeft;
        end
      end
    end

    cfa_cell #(.W(FreeW), .RstVal((i == 0) ? FreeRst : FreeW'(0))) u_cell (
      .clk_i,
      .rst_ni,
      .op_i   (f_op[i]),
      .left_i ((i == 0) ? FreeW'(0) : f_q[(i == 0) ? 0 : i - 1]),
      .right_i((i == N - 1) ? f_tail : f_q[(i == N - 1) ? 0 : i + 1]),
      .load_i (f_ld),
      .q_o    (f_q[i])
    );
  end

  // Allocation table ring cells.
  for (genvar i = 0; i < MAX_ALLOCS; i++) begin : g_live
    always_comb begin
      l_op[i] = cfa_pkg::CellHold;
      if (cfg_we_i) begin
        l_op[i] = cfa_pkg::CellClear;
      end else if (state_q == StLscan) begin
        l_op[i] = cfa_pkg::CellRight;
      end else if (state_q == StCommit) begin
        if (is_alloc && (LIdxW'(i) == slot_idx_q)) begin
          l_op[i] = cfa_pkg::CellLoad;
        end else if (!is_alloc && (LIdxW'(i) == hit_idx_q)) begin
          l_op[i] = cfa_pkg::CellClear;
        end
      end
    end

    cfa_cell #(.W(LiveW), .RstVal(LiveW'(0))) u_cell (
      .clk_i,
      .rst_ni,
      .op_i   (l_op[i]),
      .left_i (LiveW'(0)),
      .right_i(l_q[(i == MAX_ALLOCS - 1) ? 0 : i + 1]),
      .load_i (l_ld),
      .q_o    (l_q[i])
    );
  end

  // Sequencer, scan trackers and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      out_valid_q  <= 1'b0;
      cnt_q        <= '0;
      fc_q         <= FCntW'(1);
      cap_q        <= CapMax;
      atot_q       <= '0;
      hc_q         <= 16'd1;
      sel_found_q  <= 1'b0;
      r_found_q    <= 1'b0;
      slot_found_q <= 1'b0;
      hit_found_q  <= 1'b0;
      p_q          <= '0;
    end else begin
      if (out_valid_q && !out_stall_i && (state_q != StOut)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        StIdle: begin
          if (cfg_we_i) begin
            cap_q  <= cap_new;
            fc_q   <= FCntW'(1);
            hc_q   <= 16'd1;
            atot_q <= '0;
          end
          if (in_valid_i) begin
            req_q        <= in_word_i;
            status_q     <= cfa_pkg::StatOk;
            newh_q       <= '0;
            base_q       <= '0;
            h_q          <= hc_q;
            cnt_q        <= '0;
            ftot_q       <= '0;
            big_q        <= '0;
            sel_found_q  <= 1'b0;
            r_found_q    <= 1'b0;
            slot_found_q <= 1'b0;
            hit_found_q  <= 1'b0;
            p_q          <= '0;
            state_q <= (in_word_i.kind == cfa_pkg::KindFree) ? StLscan : StFscan;
          end
        end
        StFscan: begin
          if (f_q[0].valid) begin
            if (is_alloc) begin
              if ((f_q[0].len >= req_q.request_size) &&
                  (!sel_found_q ||
                   ((req_q.strategy == cfa_pkg::StratBest) && (f_q[0].len < sel_len_q)) ||
                   ((req_q.strategy == cfa_pkg::StratWorst) && (f_q[0].len > sel_len_q))))
              begin
                sel_found_q <= 1'b1;
                sel_idx_q   <= FCntW'(cnt_q);
                sel_start_q <= f_q[0].start;
                sel_len_q   <= f_q[0].len;
              end
            end else if (f_q[0].start < hit_addr_q) begin
              p_q          <= FCntW'(cnt_q) + FCntW'(1);
              prev_start_q <= f_q[0].start;
              prev_len_q   <= f_q[0].len;
            end else if (!r_found_q) begin
              r_found_q <= 1'b1;
              r_start_q <= f_q[0].start;
              r_len_q   <= f_q[0].len;
            end
          end
          if (last_f) begin
            cnt_q   <= '0;
            state_q <= is_alloc ? StLscan : StCommit;
          end else begin
            cnt_q <= cnt_q + FIdxW'(1);
          end
        end
        StLscan: begin
          if (l_q[0].valid && (l_q[0].handle == key) && (key != 16'd0) && !hit_found_q) begin
            hit_found_q <= 1'b1;
            hit_idx_q   <= cnt_q[LIdxW-1:0];
            hit_addr_q  <= l_q[0].addr;
            hit_len_q   <= l_q[0].len;
          end
          if (!l_q[0].valid && !slot_found_q) begin
            slot_found_q <= 1'b1;
            slot_idx_q   <= cnt_q[LIdxW-1:0];
          end
          if (last_l) begin
            cnt_q   <= '0;
            state_q <= StDecide;
          end else begin
            cnt_q <= cnt_q + FIdxW'(1);
          end
        end
        StDecide: begin
          if (!is_alloc) begin
            if (hit_found_q) begin
              state_q <= StFscan;
            end else begin
              status_q <= cfa_pkg::StatUnknown;
              state_q  <= StTscan;
            end
          end else if (req_q.request_size == 17'd0) begin
            status_q <= cfa_pkg::StatZeroSize;
            state_q  <= StTscan;
          end else if (!sel_found_q) begin
            status_q <= cfa_pkg::StatNoFit;
            state_q  <= StTscan;
          end else if (!slot_found_q) begin
            status_q <= cfa_pkg::StatFull;
            state_q  <= StTscan;
          end else if (hit_found_q) begin
            // Candidate handle is still live: try the next one.
            h_q          <= next_handle(h_q);
            hit_found_q  <= 1'b0;
            slot_found_q <= 1'b0;
            state_q      <= StLscan;
          end else begin
            state_q <= StCommit;
          end
        end
        StCommit: begin
          fc_q <= fc_next;
          if (is_alloc) begin
            newh_q <= h_q;
            base_q <= sel_start_q;
            hc_q   <= next_handle(h_q);
            atot_q <= atot_q + req_q.request_size;
          end else begin
            atot_q <= atot_q - hit_len_q;
          end
          cnt_q   <= '0;
          state_q <= StTscan;
        end
        StTscan: begin
          if (f_q[0].valid) begin
            ftot_q <= ftot_q + f_q[0].len;
            if (f_q[0].len > big_q) begin
              big_q <= f_q[0].len;
            end
          end
          if (last_f) begin
            cnt_q   <= '0;
            state_q <= StOut;
          end else begin
            cnt_q <= cnt_q + FIdxW'(1);
          end
        end
        StOut: begin
          if (!out_valid_q || !out_stall_i) begin
            out_word_q  <= '{status: status_q, new_handle: newh_q, base_address: base_q,
                             free_total: ftot_q, allocated_total: atot_q,
                             largest_free: big_q};
            out_valid_q <= 1'b1;
            state_q     <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign in_stall_o  = (state_q != StIdle);
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  // Checks on the sequencer and the bookkeeping.
  `CFA_ASSERT_NEXT(a_accept_leaves_idle, clk_i, rst_ni, in_valid_i && !in_stall_o, state_q != StIdle)
  `CFA_ASSERT_SAME(a_commit_has_room, clk_i, rst_ni, (state_q == StCommit) && is_alloc, sel_found_q && slot_found_q && (req_q.request_size != 17'd0))
  `CFA_ASSERT_SAME(a_alloc_within_cap, clk_i, rst_ni, state_q == StIdle, (atot_q <= cap_q) && (fc_q <= FCntW'(N)))

endmodule
